FILE: hw/rtl/rsa_pkg.sv
package rsa_pkg;

    // Fixed word geometry
    localparam int WORD_W = 32;
    localparam int CNT_W = $clog2(WORD_W);
    localparam int OPC_W = 5;
    localparam int RSA_STACK_DEPTH = 5;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH = 5'd0,
        OP_ADD  = 5'd1,
        OP_SUB  = 5'd2,
        OP_MUL  = 5'd3,
        OP_DIV  = 5'd4,
        OP_MOD  = 5'd5,
        OP_NEG  = 5'd6,
        OP_NOT  = 5'd7,
        OP_AND  = 5'd8,
        OP_OR   = 5'd9,
        OP_XOR  = 5'd10,
        OP_SHR  = 5'd11,
        OP_SHL  = 5'd12,
        OP_EQ   = 5'd13,
        OP_DROP = 5'd14,
        OP_SWAP = 5'd15,
        OP_DUP  = 5'd16,
        OP_ROT  = 5'd17
    } opcode_t;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic signed [WORD_W-1:0] push_value;
    } rsa_cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic signed [WORD_W-1:0] second_value;
        logic                     divide_error;
    } rsa_res_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_DONE
    } seq_state_t;

    // Serial ALU states
    typedef enum logic [1:0] {
        AL_IDLE,
        AL_PREP,
        AL_ITER,
        AL_FIX
    } alu_state_t;

    // Stack moves
    typedef enum logic [2:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP1,
        STK_POP2,
        STK_POP1_SET,
        STK_SET_TOP,
        STK_SWAP,
        STK_ROT
    } stk_act_t;

    // Sequencer to ALU control
    typedef struct packed {
        logic    start;
        opcode_t op;
    } alu_ctl_t;

    // ALU back to sequencer
    typedef struct packed {
        logic  done;
        word_t result;
    } alu_sts_t;

endpackage

FILE: hw/rtl/rsa_alu.sv
module rsa_alu
    import rsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_ctl_t ctl,
    input  word_t    a,
    input  word_t    b,
    output alu_sts_t sts
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    alu_state_t       state_reg, state_next;
    opcode_t          op_reg, op_next;
    word_t            x_reg, x_next;
    word_t            y_reg, y_next;
    word_t            acc_reg, acc_next;
    logic             carry_reg, carry_next;
    logic             flag_reg, flag_next;
    logic             na_reg, na_next;
    logic             nb_reg, nb_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic              yb;
    logic              sb;
    logic [WORD_W:0]   rem_wide;
    logic [WORD_W:0]   rem_diff;
    word_t             x_neg;
    word_t             acc_neg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AL_IDLE:
            begin
                if (ctl.start)
                begin
                    if (ctl.op == OP_DIV || ctl.op == OP_MOD)
                        state_next = AL_PREP;
                    else
                        state_next = AL_ITER;
                end
            end
            AL_PREP: state_next = AL_ITER;
            AL_ITER:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = AL_FIX;
            end
            AL_FIX: state_next = AL_IDLE;
            default: state_next = AL_IDLE;
        endcase
    end

    // Negators for sign fixup; x_neg also takes the dividend magnitude
    assign x_neg   = word_t'(~x_reg + word_t'(1));
    assign acc_neg = word_t'(~acc_reg + word_t'(1));

    // Serial bit of the adder and one restoring divide step
    assign yb       = y_reg[0] ^ (op_reg != OP_ADD);
    assign sb       = x_reg[0] ^ yb ^ carry_reg;
    assign rem_wide = {acc_reg, x_reg[WORD_W-1]};
    assign rem_diff = rem_wide - {1'b0, y_reg};

    // Datapath: load, take magnitudes, shift one bit per cycle
    always_comb
    begin
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        flag_next  = flag_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            AL_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next    = ctl.op;
                    x_next     = (ctl.op == OP_NEG) ? '0 : a;
                    y_next     = (ctl.op == OP_NEG) ? a : b;
                    acc_next   = '0;
                    carry_next = (ctl.op == OP_SUB) || (ctl.op == OP_NEG);
                    flag_next  = 1'b1;
                    na_next    = a[WORD_W-1];
                    nb_next    = b[WORD_W-1];
                    cnt_next   = '0;
                end
            end
            AL_PREP:
            begin
                x_next = na_reg ? x_neg : x_reg;
                y_next = nb_reg ? word_t'(~y_reg + word_t'(1)) : y_reg;
            end
            AL_ITER:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                case (op_reg)
                    OP_ADD, OP_SUB, OP_NEG:
                    begin
                        acc_next   = {sb, acc_reg[WORD_W-1:1]};
                        carry_next = (x_reg[0] & yb) | (x_reg[0] & carry_reg)
                                   | (yb & carry_reg);
                        x_next     = x_reg >> 1;
                        y_next     = y_reg >> 1;
                    end
                    OP_NOT:
                    begin
                        acc_next = {~x_reg[0], acc_reg[WORD_W-1:1]};
                        x_next   = x_reg >> 1;
                    end
                    OP_AND, OP_OR, OP_XOR:
                    begin
                        if (op_reg == OP_AND)
                            acc_next = {x_reg[0] & y_reg[0], acc_reg[WORD_W-1:1]};
                        else if (op_reg == OP_OR)
                            acc_next = {x_reg[0] | y_reg[0], acc_reg[WORD_W-1:1]};
                        else
                            acc_next = {x_reg[0] ^ y_reg[0], acc_reg[WORD_W-1:1]};
                        x_next = x_reg >> 1;
                        y_next = y_reg >> 1;
                    end
                    OP_EQ:
                    begin
                        flag_next = flag_reg & ~(x_reg[0] ^ y_reg[0]);
                        x_next    = x_reg >> 1;
                        y_next    = y_reg >> 1;
                    end
                    OP_MUL:
                    begin
                        if (y_reg[0])
                            acc_next = acc_reg + x_reg;
                        x_next = x_reg << 1;
                        y_next = y_reg >> 1;
                    end
                    OP_SHR:
                    begin
                        if (cnt_reg < y_reg[CNT_W-1:0])
                            x_next = {x_reg[WORD_W-1], x_reg[WORD_W-1:1]};
                    end
                    OP_SHL:
                    begin
                        if (cnt_reg < y_reg[CNT_W-1:0])
                            x_next = x_reg << 1;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        // Keep the difference when the divisor fits
                        if (!rem_diff[WORD_W])
                        begin
                            acc_next = rem_diff[WORD_W-1:0];
                            x_next   = {x_reg[WORD_W-2:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = rem_wide[WORD_W-1:0];
                            x_next   = {x_reg[WORD_W-2:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            AL_FIX:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Result select and sign fixup
    always_comb
    begin
        sts.done = (state_reg == AL_FIX);
        case (op_reg)
            OP_SHR, OP_SHL: sts.result = x_reg;
            OP_EQ:          sts.result = word_t'(flag_reg);
            OP_DIV:         sts.result = (na_reg ^ nb_reg) ? x_neg : x_reg;
            OP_MOD:         sts.result = na_reg ? acc_neg : acc_reg;
            default:        sts.result = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= AL_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
        flag_reg  <= flag_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        cnt_reg   <= cnt_next;
    end

endmodule

FILE: hw/rtl/rpn_stack_alu_core.sv
// Flow: a request is taken in S_IDLE and held; push, dup, drop, swap, rot, unknown codes
// and a divide by zero go from S_LOAD to S_DONE, and other ALU codes run through S_RUN
// (div and mod with an extra prep step). A new request waits until the result is loaded.
// ALU codes run the 32-step bit-serial loop of the ALU (one bit per cycle).
// Reset: asynchronous, clears every stack entry to zero and drops any pending result.
module rpn_stack_alu_core
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = RSA_STACK_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  rsa_cmd_t cmd_data,
    output logic     res_valid,
    input  logic     res_stall,
    output rsa_res_t res_data
);

    seq_state_t state_reg, state_next;
    rsa_cmd_t   cmd_reg, cmd_next;
    logic       err_reg, err_next;
    word_t      stk_reg [STACK_DEPTH];
    word_t      stk_next [STACK_DEPTH];
    logic       res_valid_reg, res_valid_next;
    rsa_res_t   res_reg, res_next;

    word_t      up1 [STACK_DEPTH];
    word_t      up2 [STACK_DEPTH];
    word_t      dn [STACK_DEPTH];
    word_t      push_word;
    word_t      set_word;
    stk_act_t   stk_act;

    opcode_t    op;
    logic       is_alu;
    logic       div_zero;
    logic       cmd_take;
    logic       res_load;
    alu_ctl_t   alu_ctl;
    alu_sts_t   alu_sts;

    // Decode the held request
    assign op       = opcode_t'(cmd_reg.opcode);
    assign is_alu   = (cmd_reg.opcode >= OP_ADD) && (cmd_reg.opcode <= OP_EQ);
    assign div_zero = ((op == OP_DIV) || (op == OP_MOD)) && (stk_reg[1] == '0);

    // Shifted views of the stack
    for (genvar gi = 0; gi < STACK_DEPTH; gi++)
    begin : g_view
        if (gi < STACK_DEPTH - 1)
        begin : g_up1
            assign up1[gi] = stk_reg[gi+1];
        end
        else
        begin : g_up1_end
            assign up1[gi] = '0;
        end
        if (gi < STACK_DEPTH - 2)
        begin : g_up2
            assign up2[gi] = stk_reg[gi+2];
        end
        else
        begin : g_up2_end
            assign up2[gi] = '0;
        end
        if (gi == 0)
        begin : g_dn_top
            assign dn[gi] = push_word;
        end
        else
        begin : g_dn
            assign dn[gi] = stk_reg[gi-1];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (is_alu && !div_zero)
                    state_next = S_RUN;
                else
                    state_next = S_DONE;
            end
            S_RUN:
            begin
                if (alu_sts.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_stall     = (state_reg != S_IDLE);
        cmd_take      = 1'b0;
        res_load      = 1'b0;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = op;
        stk_act       = STK_HOLD;
        push_word     = stk_reg[0];
        set_word      = alu_sts.result;
        err_next      = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_take = cmd_valid;
            end
            S_LOAD:
            begin
                err_next = div_zero;
                if (div_zero)
                    stk_act = STK_POP2;
                else if (is_alu)
                    alu_ctl.start = 1'b1;
                else
                begin
                    case (op)
                        OP_PUSH:
                        begin
                            stk_act   = STK_PUSH;
                            push_word = word_t'(cmd_reg.push_value);
                        end
                        OP_DUP:  stk_act = STK_PUSH;
                        OP_DROP: stk_act = STK_POP1;
                        OP_SWAP: stk_act = STK_SWAP;
                        OP_ROT:  stk_act = STK_ROT;
                        default: stk_act = STK_HOLD;
                    endcase
                end
            end
            S_RUN:
            begin
                if (alu_sts.done)
                begin
                    if (op == OP_NEG || op == OP_NOT)
                        stk_act = STK_SET_TOP;
                    else
                        stk_act = STK_POP1_SET;
                end
            end
            S_DONE:
            begin
                res_load = !res_valid_reg || !res_stall;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Hold the request while it runs
    always_comb
    begin
        cmd_next = cmd_reg;
        if (cmd_take)
            cmd_next = cmd_data;
    end

    // Stack update
    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            stk_next[i] = stk_reg[i];
        end
        case (stk_act)
            STK_PUSH:
            begin
                for (int i = 0; i < STACK_DEPTH; i++)
                    stk_next[i] = dn[i];
            end
            STK_POP1:
            begin
                for (int i = 0; i < STACK_DEPTH; i++)
                    stk_next[i] = up1[i];
            end
            STK_POP2:
            begin
                for (int i = 0; i < STACK_DEPTH; i++)
                    stk_next[i] = up2[i];
            end
            STK_POP1_SET:
            begin
                for (int i = 0; i < STACK_DEPTH; i++)
                    stk_next[i] = up1[i];
                stk_next[0] = set_word;
            end
            STK_SET_TOP:
            begin
                stk_next[0] = set_word;
            end
            STK_SWAP:
            begin
                stk_next[0] = stk_reg[1];
                stk_next[1] = stk_reg[0];
            end
            STK_ROT:
            begin
                stk_next[0] = stk_reg[1];
                stk_next[1] = stk_reg[2];
                stk_next[2] = stk_reg[0];
            end
            default:
            begin
                stk_next[0] = stk_reg[0];
            end
        endcase
    end

    // Result register: load on finish, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_load)
        begin
            res_valid_next        = 1'b1;
            res_next.top_value    = $signed(stk_reg[0]);
            res_next.second_value = $signed(stk_reg[1]);
            res_next.divide_error = err_reg;
        end
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    rsa_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (alu_ctl),
        .a     (stk_reg[0]),
        .b     (stk_reg[1]),
        .sts   (alu_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
            for (int i = 0; i < STACK_DEPTH; i++)
                stk_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            err_reg       <= err_next;
            for (int i = 0; i < STACK_DEPTH; i++)
                stk_reg[i] <= stk_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

endmodule
